// File: rtl/dcl_pkg.sv
package dcl_pkg;

  // sizes of the point set and of the fields
  localparam int MaxPoints = 64;
  localparam int IdxW      = 6;
  localparam int CntW      = 7;
  localparam int CoordW    = 16;
  localparam int Dims      = 4;
  localparam int PointW    = CoordW * Dims;
  localparam int LabelW    = 7;
  localparam int RadiusW   = 20;
  localparam int CfgIdxW   = 2;

  // label codes that are not cluster numbers
  localparam logic [LabelW-1:0] LblUnseen = 7'h7E;
  localparam logic [LabelW-1:0] LblNoise  = 7'h7F;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRadius = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMinNb  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMetric = 2'd2;

  typedef enum logic [1:0] {
    METRIC_EUCL,
    METRIC_MANH,
    METRIC_CHEB,
    METRIC_COS
  } metric_e;

  typedef struct packed {
    metric_e              metric;
    logic [RadiusW-1:0]   radius;
  } dist_cfg_t;

  typedef struct packed {
    logic              start;
    logic [PointW-1:0] a;
    logic [PointW-1:0] b;
  } dist_req_t;

  typedef struct packed {
    logic done;
    logic near;
  } dist_rsp_t;

  // one coordinate of a packed point, coord_0 in the low bits
  function automatic logic signed [CoordW-1:0] coord_of(logic [PointW-1:0] pt, logic [1:0] d);
    logic signed [CoordW-1:0] c;
    c = pt[{d, 4'b0000} +: CoordW];
    return c;
  endfunction

endpackage

// File: rtl/dcl_if.sv
interface dcl_pnt_if;
  logic                                valid;
  logic                                ready;
  logic signed [dcl_pkg::CoordW-1:0]   coord_0;
  logic signed [dcl_pkg::CoordW-1:0]   coord_1;
  logic signed [dcl_pkg::CoordW-1:0]   coord_2;
  logic signed [dcl_pkg::CoordW-1:0]   coord_3;
  logic                                final_point;
  modport source (output valid, coord_0, coord_1, coord_2, coord_3, final_point, input ready);
  modport sink   (input valid, coord_0, coord_1, coord_2, coord_3, final_point, output ready);
endinterface

interface dcl_res_if;
  logic                               valid;
  logic                               ready;
  logic [dcl_pkg::IdxW-1:0]           point_index;
  logic signed [dcl_pkg::LabelW-1:0]  label;
  logic                               last_label;
  logic [dcl_pkg::CntW-1:0]           cluster_count;
  logic [dcl_pkg::CntW-1:0]           noise_count;
  modport source (output valid, point_index, label, last_label, cluster_count, noise_count,
                  input ready);
  modport sink   (input valid, point_index, label, last_label, cluster_count, noise_count,
                  output ready);
endinterface

interface dcl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dcl_pkg::CfgIdxW-1:0]   index;
  logic [dcl_pkg::RadiusW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/dcl_ram.sv
module dcl_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/dcl_dist.sv
module dcl_dist (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dcl_pkg::dist_cfg_t cfg_i,
  input  dcl_pkg::dist_req_t req_i,
  output dcl_pkg::dist_rsp_t rsp_o
);

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_ACC  = 3'd1;
  localparam logic [2:0] D_CX   = 3'd2;
  localparam logic [2:0] D_BM   = 3'd3;
  localparam logic [2:0] D_CMP  = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [dcl_pkg::PointW-1:0]   a_q, a_d, b_q, b_d;
  logic [1:0]                   dim_q, dim_d, sub_q, sub_d, bm_q, bm_d;
  logic [34:0]                  acc_q, acc_d;
  logic signed [34:0]           dot_q, dot_d;
  logic [33:0]                  na_q, na_d, nb_q, nb_d;
  logic [15:0]                  kk_q, kk_d;
  logic [83:0]                  lhs_q, lhs_d, rhs_q, rhs_d;
  logic [67:0]                  nn_q, nn_d, lo_q, lo_d;
  logic                         near_q, near_d, done_q, done_d;

  logic [dcl_pkg::RadiusW-1:0]  r_eff;
  logic                         is_cos, last_dim, dot_neg;
  logic signed [15:0]           ca, cb;
  logic signed [16:0]           diff, opx, opy;
  logic signed [33:0]           prod;
  logic [16:0]                  absd;
  logic signed [9:0]            k;
  logic [7:0]                   kabs;
  logic [15:0]                  kk;
  logic [34:0]                  dot_abs;
  logic [33:0]                  bx, by;
  logic [67:0]                  bprod;
  logic [39:0]                  rr;

  // operand selection and the four multipliers
  always_comb begin
    r_eff    = (cfg_i.radius == '0) ? 20'd1 : cfg_i.radius;
    is_cos   = (cfg_i.metric == dcl_pkg::METRIC_COS);
    ca       = dcl_pkg::coord_of(a_q, dim_q);
    cb       = dcl_pkg::coord_of(b_q, dim_q);
    diff     = 17'({ca[15], ca}) - 17'({cb[15], cb});
    absd     = diff[16] ? 17'(-diff) : 17'(diff);
    if (!is_cos) begin
      opx = diff;
      opy = diff;
    end else begin
      case (sub_q)
        2'd0:    begin opx = 17'(ca); opy = 17'(cb); end
        2'd1:    begin opx = 17'(ca); opy = 17'(ca); end
        default: begin opx = 17'(cb); opy = 17'(cb); end
      endcase
    end
    prod     = opx * opy;
    last_dim = (dim_q == 2'd3) && (!is_cos || (sub_q == 2'd2));
    k        = 10'sd256 - $signed({1'b0, r_eff[8:0]});
    kabs     = k[9] ? 8'(-k) : 8'(k);
    kk       = kabs * kabs;
    dot_neg  = dot_q[34];
    dot_abs  = dot_neg ? 35'(-dot_q) : 35'(dot_q);
    case (bm_q)
      2'd0:    begin bx = dot_abs[33:0]; by = dot_abs[33:0]; end
      2'd1:    begin bx = na_q;          by = nb_q;          end
      2'd2:    begin bx = nn_q[33:0];    by = {18'b0, kk_q}; end
      default: begin bx = nn_q[67:34];   by = {18'b0, kk_q}; end
    endcase
    bprod    = bx * by;
    rr       = r_eff * r_eff;
  end

  // sequencing over dimensions, cosine early outcomes and products, then the compare
  always_comb begin
    state_d = state_q;
    a_d = a_q;  b_d = b_q;
    dim_d = dim_q;  sub_d = sub_q;  bm_d = bm_q;
    acc_d = acc_q;  dot_d = dot_q;  na_d = na_q;  nb_d = nb_q;
    kk_d = kk_q;  lhs_d = lhs_q;  rhs_d = rhs_q;  nn_d = nn_q;  lo_d = lo_q;
    near_d = near_q;
    done_d = 1'b0;
    unique case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          a_d = req_i.a;  b_d = req_i.b;
          dim_d = '0;  sub_d = '0;
          acc_d = '0;  dot_d = '0;  na_d = '0;  nb_d = '0;
          state_d = D_ACC;
        end
      end
      D_ACC: begin
        if (is_cos) begin
          case (sub_q)
            2'd0:    dot_d = dot_q + 35'(prod);
            2'd1:    na_d  = na_q + 34'(prod);
            default: nb_d  = nb_q + 34'(prod);
          endcase
          if (sub_q == 2'd2) begin
            sub_d = '0;
            dim_d = dim_q + 2'd1;
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end else begin
          case (cfg_i.metric)
            dcl_pkg::METRIC_EUCL: acc_d = acc_q + 35'(prod);
            dcl_pkg::METRIC_MANH: acc_d = acc_q + 35'(absd);
            default:              acc_d = (35'(absd) > acc_q) ? 35'(absd) : acc_q;
          endcase
          dim_d = dim_q + 2'd1;
        end
        if (last_dim) begin
          state_d = is_cos ? D_CX : D_CMP;
        end
      end
      D_CX: begin
        if (na_q == '0 || nb_q == '0) begin
          near_d = (r_eff >= 20'd256);
          done_d = 1'b1;
          state_d = D_IDLE;
        end else if (r_eff >= 20'd512) begin
          near_d = 1'b1;
          done_d = 1'b1;
          state_d = D_IDLE;
        end else if (!dot_neg && (k <= 10'sd0)) begin
          near_d = 1'b1;
          done_d = 1'b1;
          state_d = D_IDLE;
        end else if (dot_neg && (k >= 10'sd0)) begin
          near_d = 1'b0;
          done_d = 1'b1;
          state_d = D_IDLE;
        end else begin
          kk_d = kk;
          bm_d = '0;
          state_d = D_BM;
        end
      end
      D_BM: begin
        case (bm_q)
          2'd0:    lhs_d = {bprod, 16'b0};
          2'd1:    nn_d  = bprod;
          2'd2:    lo_d  = bprod;
          default: rhs_d = 84'(lo_q) + {bprod[49:0], 34'b0};
        endcase
        bm_d = bm_q + 2'd1;
        if (bm_q == 2'd3) begin
          state_d = D_CMP;
        end
      end
      D_CMP: begin
        if (is_cos) begin
          near_d = dot_neg ? (lhs_q <= rhs_q) : (lhs_q >= rhs_q);
        end else if (cfg_i.metric == dcl_pkg::METRIC_EUCL) begin
          near_d = ({5'b0, acc_q} <= rr);
        end else begin
          near_d = (acc_q <= 35'(r_eff));
        end
        done_d = 1'b1;
        state_d = D_IDLE;
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      near_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      near_q  <= near_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;  b_q <= b_d;
    dim_q <= dim_d;  sub_q <= sub_d;  bm_q <= bm_d;
    acc_q <= acc_d;  dot_q <= dot_d;  na_q <= na_d;  nb_q <= nb_d;
    kk_q <= kk_d;  lhs_q <= lhs_d;  rhs_q <= rhs_d;  nn_q <= nn_d;  lo_q <= lo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.near = near_q;

endmodule

// File: rtl/density_clustering_engine.sv
// Density clustering engine. Points are loaded one word per cycle into a point memory
// (up to 64, further points dropped); the word with final_point set starts a DBSCAN pass
// over the set, during which no point word is taken. The pass makes up to 2*N*N
// distance checks, run one at a time through a single sequential distance unit; for
// cosine, four wide products are formed one after another on a shared multiplier.
// Labels then leave one word per point in index order, each read from the label
// memory, registered and held until the sink is ready. Point words are taken again
// once the last label has gone. Configuration writes are taken at any time and must
// be made only while the block is idle.
module density_clustering_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  dcl_pnt_if.sink    pnt_i,
  dcl_cfg_if.sink    cfg_i,
  dcl_res_if.source  res_o
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_INIT    = 4'd1;
  localparam logic [3:0] ST_OUTER   = 4'd2;
  localparam logic [3:0] ST_O_LB    = 4'd3;
  localparam logic [3:0] ST_O_PT    = 4'd4;
  localparam logic [3:0] ST_SC_RD   = 4'd5;
  localparam logic [3:0] ST_SC_DS   = 4'd6;
  localparam logic [3:0] ST_SC_WT   = 4'd7;
  localparam logic [3:0] ST_SC_END  = 4'd8;
  localparam logic [3:0] ST_Q_TOP   = 4'd9;
  localparam logic [3:0] ST_Q_RD1   = 4'd10;
  localparam logic [3:0] ST_Q_RD2   = 4'd11;
  localparam logic [3:0] ST_Q_PT    = 4'd12;
  localparam logic [3:0] ST_EM_RD   = 4'd13;
  localparam logic [3:0] ST_EM_LD   = 4'd14;
  localparam logic [3:0] ST_EM_HOLD = 4'd15;

  localparam logic [dcl_pkg::CntW-1:0] Full = dcl_pkg::CntW'(dcl_pkg::MaxPoints);

  logic [3:0]                     state_q, state_d;
  logic [dcl_pkg::CntW-1:0]       cnt_q, cnt_d, n_q, n_d, i_q, i_d, j_q, j_d;
  logic [dcl_pkg::CntW-1:0]       nb_q, nb_d, clus_q, clus_d, noise_q, noise_d;
  logic [dcl_pkg::CntW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [dcl_pkg::MaxPoints-1:0]  qf_q, qf_d;
  logic                           ctx_q, ctx_d, mode_q, mode_d;
  logic [dcl_pkg::LabelW-1:0]     cur_id_q, cur_id_d, lab_j_q, lab_j_d;
  logic [dcl_pkg::IdxW-1:0]       qp_q, qp_d;
  logic [dcl_pkg::PointW-1:0]     pa_q, pa_d;
  logic [dcl_pkg::LabelW-1:0]     olab_q, olab_d;
  logic [dcl_pkg::IdxW-1:0]       oidx_q, oidx_d;
  logic                           olast_q, olast_d;

  logic [dcl_pkg::RadiusW-1:0]    radius_q;
  logic [dcl_pkg::CntW-1:0]       min_nb_q;
  dcl_pkg::metric_e               metric_q;

  logic                           p_we;
  logic [dcl_pkg::IdxW-1:0]       p_raddr;
  logic [dcl_pkg::PointW-1:0]     p_wdata, p_rdata;
  logic                           l_we;
  logic [dcl_pkg::IdxW-1:0]       l_waddr, l_raddr;
  logic [dcl_pkg::LabelW-1:0]     l_wdata, l_rdata;
  logic                           s_we;
  logic [dcl_pkg::IdxW-1:0]       s_waddr, s_wdata, s_raddr, s_rdata;

  logic                           pnt_acc, j_last, need_met;
  logic [dcl_pkg::CntW-1:0]       need;
  dcl_pkg::dist_cfg_t             dcfg;
  dcl_pkg::dist_req_t             dreq;
  dcl_pkg::dist_rsp_t             drsp;

  // configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 20'd256;
      min_nb_q <= 7'd4;
      metric_q <= dcl_pkg::METRIC_EUCL;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        dcl_pkg::RegRadius: radius_q <= cfg_i.data;
        dcl_pkg::RegMinNb:  min_nb_q <= cfg_i.data[dcl_pkg::CntW-1:0];
        dcl_pkg::RegMetric: metric_q <= dcl_pkg::metric_e'(cfg_i.data[1:0]);
        default: ;
      endcase
    end
  end

  // memories
  dcl_ram #(.Width(dcl_pkg::PointW), .Depth(dcl_pkg::MaxPoints)) u_point_ram (
    .clk_i, .we_i(p_we), .waddr_i(cnt_q[dcl_pkg::IdxW-1:0]), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );
  dcl_ram #(.Width(dcl_pkg::LabelW), .Depth(dcl_pkg::MaxPoints)) u_label_ram (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .raddr_i(l_raddr), .rdata_o(l_rdata)
  );
  dcl_ram #(.Width(dcl_pkg::IdxW), .Depth(dcl_pkg::MaxPoints)) u_seed_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  // distance unit
  assign dcfg.metric = metric_q;
  assign dcfg.radius = radius_q;
  assign dreq.start  = (state_q == ST_SC_DS);
  assign dreq.a      = pa_q;
  assign dreq.b      = p_rdata;

  dcl_dist u_dist (.clk_i, .rst_ni, .cfg_i(dcfg), .req_i(dreq), .rsp_o(drsp));

  assign pnt_i.ready = (state_q == ST_IDLE);
  assign pnt_acc     = pnt_i.valid && pnt_i.ready;
  assign p_wdata     = {pnt_i.coord_3, pnt_i.coord_2, pnt_i.coord_1, pnt_i.coord_0};
  assign p_we        = pnt_acc && (cnt_q < Full);
  assign need        = (min_nb_q == '0) ? 7'd1 : min_nb_q;
  assign need_met    = (nb_q >= need);
  assign j_last      = ((j_q + 7'd1) == n_q);

  // clustering sequencer
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;  n_d = n_q;  i_d = i_q;  j_d = j_q;
    nb_d = nb_q;  clus_d = clus_q;  noise_d = noise_q;
    head_d = head_q;  tail_d = tail_q;  qf_d = qf_q;
    ctx_d = ctx_q;  mode_d = mode_q;  cur_id_d = cur_id_q;  lab_j_d = lab_j_q;
    qp_d = qp_q;  pa_d = pa_q;
    olab_d = olab_q;  oidx_d = oidx_q;  olast_d = olast_q;
    p_raddr = j_q[dcl_pkg::IdxW-1:0];
    l_we = 1'b0;  l_waddr = j_q[dcl_pkg::IdxW-1:0];  l_wdata = dcl_pkg::LblUnseen;
    l_raddr = j_q[dcl_pkg::IdxW-1:0];
    s_we = 1'b0;  s_waddr = tail_q[dcl_pkg::IdxW-1:0];  s_wdata = j_q[dcl_pkg::IdxW-1:0];
    s_raddr = head_q[dcl_pkg::IdxW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (pnt_acc) begin
          if (cnt_q < Full) begin
            cnt_d = cnt_q + 7'd1;
          end
          if (pnt_i.final_point) begin
            n_d = (cnt_q < Full) ? cnt_q + 7'd1 : cnt_q;
            j_d = '0;
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        l_we = 1'b1;
        j_d = j_q + 7'd1;
        if (j_last) begin
          i_d = '0;  clus_d = '0;  noise_d = '0;
          state_d = ST_OUTER;
        end
      end
      ST_OUTER: begin
        l_raddr = i_q[dcl_pkg::IdxW-1:0];
        if (i_q == n_q) begin
          j_d = '0;
          state_d = ST_EM_RD;
        end else begin
          state_d = ST_O_LB;
        end
      end
      ST_O_LB: begin
        p_raddr = i_q[dcl_pkg::IdxW-1:0];
        if (l_rdata != dcl_pkg::LblUnseen) begin
          i_d = i_q + 7'd1;
          state_d = ST_OUTER;
        end else begin
          state_d = ST_O_PT;
        end
      end
      ST_O_PT: begin
        pa_d = p_rdata;  ctx_d = 1'b0;  mode_d = 1'b0;  j_d = '0;  nb_d = '0;
        state_d = ST_SC_RD;
      end
      // scan of all points against the reference point
      ST_SC_RD: begin
        state_d = ST_SC_DS;
      end
      ST_SC_DS: begin
        lab_j_d = l_rdata;
        state_d = ST_SC_WT;
      end
      ST_SC_WT: begin
        if (drsp.done) begin
          if (!mode_q) begin
            if (drsp.near) nb_d = nb_q + 7'd1;
          end else if (drsp.near
                       && (lab_j_q == dcl_pkg::LblUnseen || lab_j_q == dcl_pkg::LblNoise)
                       && !qf_q[j_q[dcl_pkg::IdxW-1:0]] && (tail_q < Full)) begin
            qf_d[j_q[dcl_pkg::IdxW-1:0]] = 1'b1;
            s_we = 1'b1;
            tail_d = tail_q + 7'd1;
          end
          j_d = j_q + 7'd1;
          state_d = j_last ? ST_SC_END : ST_SC_RD;
        end
      end
      ST_SC_END: begin
        l_waddr = i_q[dcl_pkg::IdxW-1:0];
        j_d = '0;
        if (mode_q) begin
          state_d = ST_Q_TOP;
        end else if (!ctx_q) begin
          l_we = 1'b1;
          if (!need_met) begin
            l_wdata = dcl_pkg::LblNoise;
            noise_d = noise_q + 7'd1;
            i_d = i_q + 7'd1;
            state_d = ST_OUTER;
          end else begin
            l_wdata = clus_q;
            cur_id_d = clus_q;
            clus_d = clus_q + 7'd1;
            qf_d = '0;  head_d = '0;  tail_d = '0;
            mode_d = 1'b1;
            state_d = ST_SC_RD;
          end
        end else if (need_met) begin
          mode_d = 1'b1;
          state_d = ST_SC_RD;
        end else begin
          state_d = ST_Q_TOP;
        end
      end
      // seed queue
      ST_Q_TOP: begin
        if (head_q < tail_q) begin
          head_d = head_q + 7'd1;
          state_d = ST_Q_RD1;
        end else begin
          i_d = i_q + 7'd1;
          state_d = ST_OUTER;
        end
      end
      ST_Q_RD1: begin
        l_raddr = s_rdata;
        qp_d = s_rdata;
        if ({1'b0, s_rdata} >= n_q) begin
          state_d = ST_Q_TOP;
        end else begin
          qf_d[s_rdata] = 1'b0;
          state_d = ST_Q_RD2;
        end
      end
      ST_Q_RD2: begin
        l_waddr = qp_q;
        l_wdata = cur_id_q;
        p_raddr = qp_q;
        if (l_rdata == dcl_pkg::LblNoise) begin
          l_we = 1'b1;
          noise_d = noise_q - 7'd1;
          state_d = ST_Q_TOP;
        end else if (l_rdata != dcl_pkg::LblUnseen) begin
          state_d = ST_Q_TOP;
        end else begin
          l_we = 1'b1;
          state_d = ST_Q_PT;
        end
      end
      ST_Q_PT: begin
        pa_d = p_rdata;  ctx_d = 1'b1;  mode_d = 1'b0;  j_d = '0;  nb_d = '0;
        state_d = ST_SC_RD;
      end
      // label words out in index order
      ST_EM_RD: begin
        state_d = ST_EM_LD;
      end
      ST_EM_LD: begin
        olab_d = l_rdata;
        oidx_d = j_q[dcl_pkg::IdxW-1:0];
        olast_d = j_last;
        state_d = ST_EM_HOLD;
      end
      ST_EM_HOLD: begin
        if (res_o.ready) begin
          if (olast_q) begin
            cnt_d = '0;
            state_d = ST_IDLE;
          end else begin
            j_d = j_q + 7'd1;
            state_d = ST_EM_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      clus_q  <= '0;
      noise_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      qf_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clus_q  <= clus_d;
      noise_q <= noise_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      qf_q    <= qf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;  i_q <= i_d;  j_q <= j_d;  nb_q <= nb_d;
    ctx_q <= ctx_d;  mode_q <= mode_d;  cur_id_q <= cur_id_d;  lab_j_q <= lab_j_d;
    qp_q <= qp_d;  pa_q <= pa_d;
    olab_q <= olab_d;  oidx_q <= oidx_d;  olast_q <= olast_d;
  end

  // result word
  assign res_o.valid         = (state_q == ST_EM_HOLD);
  assign res_o.point_index   = oidx_q;
  assign res_o.label         = olab_q;
  assign res_o.last_label    = olast_q;
  assign res_o.cluster_count = clus_q;
  assign res_o.noise_count   = noise_q;

  // checks
  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= Full) else $error("seed queue overrun");
  a_head_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("seed queue read past tail");
  a_dist_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |=> state_q == ST_SC_WT) else $error("distance check not awaited");
  a_label_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.label == dcl_pkg::LblNoise) || (olab_q < clus_q))
    else $error("label outside cluster range");

endmodule
